// ===== hdl/rse_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types, constants and tables of the row softmax engine.
// ----------------------------------------------------------------------------
package rse_pkg;

   localparam int ROW_MAX_DEF = 64;
   localparam int ELEM_W      = 32;
   localparam int ROW_LEN_W   = 7;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH = 2'd2;

   localparam logic [1:0] FMT_F32  = 2'd0;
   localparam logic [1:0] FMT_BF16 = 2'd1;
   localparam logic [1:0] FMT_F16  = 2'd2;

   localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
   localparam logic [31:0] NEG_MOST    = 32'h8000_0000;
   localparam logic [30:0] LOG2E_Q30   = 31'd1549082005;

   typedef struct packed {
      logic capture;
      logic mul;
      logic sat;
      logic store;
      logic rd;
      logic x1;
      logic x2;
      logic x3;
      logic acc;
      logic div_start;
      logic div_step;
      logic enc;
      logic clr_row;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

   function automatic logic [24:0] pow2_frac(input logic [3:0] k);
      logic [24:0] v;
      begin
         case (k)
            4'd0:    v = 25'd16777216;
            4'd1:    v = 25'd15384775;
            4'd2:    v = 25'd14107901;
            4'd3:    v = 25'd12937002;
            4'd4:    v = 25'd11863283;
            4'd5:    v = 25'd10878679;
            4'd6:    v = 25'd9975792;
            4'd7:    v = 25'd9147842;
            default: v = 25'd8388608;
         endcase
         return v;
      end
   endfunction

endpackage
`default_nettype wire

// ===== hdl/rse_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rse_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rse_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hdl/rse_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rse_datapath
// Scaling, row storage, maximum, exponent, sum, division and output encoding.
// ----------------------------------------------------------------------------
module rse_datapath #(
   parameter int ROW_MAX = rse_pkg::ROW_MAX_DEF,
   parameter int ADDR_W  = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rse_pkg::cmd_type     cmd,
   input  wire logic [ADDR_W-1:0]    addr,
   input  wire logic [31:0]          element,
   input  wire logic [1:0]           value_format,
   input  wire logic [31:0]          scale,
   output logic      [31:0]          probability,
   output rse_pkg::status_type       status
);
   import rse_pkg::*;

   typedef struct packed {
      logic              neg;
      logic              inf;
      logic              nan;
      logic [23:0]       mant;
      logic signed [9:0] ex;
   } dec_type;

   localparam logic [1:0] K_NORM = 2'd0;
   localparam logic [1:0] K_ZERO = 2'd1;
   localparam logic [1:0] K_SAT  = 2'd2;

   function automatic dec_type decode_val(input logic [31:0] bits, input logic [1:0] fmt);
      dec_type     d;
      logic [31:0] w;
      logic [4:0]  e5;
      logic [7:0]  e8;
      begin
         d  = '0;
         w  = bits;
         e5 = bits[14:10];
         e8 = 8'd0;
         if (fmt == FMT_F16) begin
            d.neg  = bits[15];
            d.inf  = (e5 == 5'h1F) && (bits[9:0] == 10'd0);
            d.nan  = (e5 == 5'h1F) && (bits[9:0] != 10'd0);
            d.mant = (e5 == 5'd0) ? {14'd0, bits[9:0]} : {13'd0, 1'b1, bits[9:0]};
            d.ex   = (e5 == 5'd0) ? -10'sd24 : $signed({5'd0, e5}) - 10'sd25;
         end else begin
            if (fmt == FMT_BF16) begin
               w = {bits[15:0], 16'h0000};
            end
            e8     = w[30:23];
            d.neg  = w[31];
            d.inf  = (e8 == 8'hFF) && (w[22:0] == 23'd0);
            d.nan  = (e8 == 8'hFF) && (w[22:0] != 23'd0);
            d.mant = (e8 == 8'd0) ? {1'b0, w[22:0]} : {1'b1, w[22:0]};
            d.ex   = (e8 == 8'd0) ? -10'sd149 : $signed({2'd0, e8}) - 10'sd150;
         end
         return d;
      end
   endfunction

   function automatic logic [31:0] encode_val(input logic [24:0] p, input logic [1:0] fmt);
      logic [4:0]  b;
      logic [31:0] m;
      logic [31:0] f32;
      logic [31:0] hp;
      logic [31:0] res;
      begin
         b = 5'd0;
         for (int k = 0; k < 25; k++) begin
            if (p[k]) begin
               b = 5'(k);
            end
         end
         if (b >= 5'd23) begin
            m = {7'd0, p} >> (b - 5'd23);
         end else begin
            m = {7'd0, p} << (5'd23 - b);
         end
         f32 = {1'b0, 8'({3'd0, b} + 8'd103), m[22:0]};
         hp  = {7'd0, p} >> (b - 5'd10);
         if (p == 25'd0) begin
            res = 32'd0;
         end else if (fmt == FMT_F16) begin
            if (p < 25'd1024) begin
               res = {7'd0, p};
            end else begin
               res = {17'd0, 5'(b - 5'd9), hp[9:0]};
            end
         end else if (fmt == FMT_BF16) begin
            res = {16'd0, f32[31:16]};
         end else begin
            res = f32;
         end
         return res;
      end
   endfunction

   dec_type            a_ff, b_ff;
   logic [47:0]        m_ff;
   logic signed [9:0]  sh_ff;
   logic               neg_ff;
   logic [1:0]         kind_ff;
   logic [31:0]        q_ff, q_in;
   logic [31:0]        max_ff;
   logic [31:0]        rd_data;
   logic [62:0]        prod_ff;
   logic [24:0]        base_ff;
   logic [41:0]        dp_ff;
   logic [4:0]         n_ff;
   logic               zero_ff;
   logic [24:0]        exp_ff, exp_in;
   logic [31:0]        sum_ff;
   logic [32:0]        r_ff;
   logic [24:0]        quo_ff;
   logic [4:0]         cnt_ff;
   logic [31:0]        out_ff;

   logic [31:0]        t_val;
   logic [32:0]        u_val;
   logic [3:0]         tab_idx;
   logic [24:0]        tab_base;
   logic [20:0]        tab_diff;
   logic [24:0]        v_val;
   logic               div_ge;
   logic [32:0]        div_rem;

   always_comb begin
      logic [31:0] lim;
      logic [31:0] mag;
      logic [79:0] wide;
      logic [47:0] rsh;
      logic [9:0]  s;
      lim  = neg_ff ? 32'h8000_0000 : 32'h7FFF_FFFF;
      wide = {32'd0, m_ff} << sh_ff[4:0];
      s    = 10'(-sh_ff);
      rsh  = m_ff >> s[5:0];
      mag  = 32'd0;
      if (kind_ff == K_SAT) begin
         mag = lim;
      end else if (kind_ff == K_NORM) begin
         if (!sh_ff[9]) begin
            if (sh_ff > 10'sd31) begin
               mag = lim;
            end else if (wide > {48'd0, lim}) begin
               mag = lim;
            end else begin
               mag = wide[31:0];
            end
         end else if (s < 10'd64) begin
            mag = (rsh > {16'd0, lim}) ? lim : rsh[31:0];
         end
      end
      q_in = neg_ff ? (32'd0 - mag) : mag;
   end

   assign t_val    = max_ff - rd_data;
   assign u_val    = prod_ff[62:30];
   assign tab_idx  = {1'b0, u_val[23:21]};
   assign tab_base = pow2_frac(tab_idx);
   assign tab_diff = 21'(tab_base - pow2_frac(tab_idx + 4'd1));
   assign v_val    = base_ff - {4'd0, dp_ff[41:21]};
   assign exp_in   = zero_ff ? 25'd0 : (v_val >> n_ff);
   assign div_ge   = r_ff >= {1'b0, sum_ff};
   assign div_rem  = div_ge ? (r_ff - {1'b0, sum_ff}) : r_ff;

   rse_ram #(
      .WIDTH (32),
      .DEPTH (ROW_MAX),
      .ADDR_W(ADDR_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.store),
      .wr_addr(addr),
      .wr_data(q_ff),
      .rd_en  (cmd.rd),
      .rd_addr(addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         a_ff <= decode_val(element, value_format);
         b_ff <= decode_val(scale, FMT_F32);
      end
      if (cmd.mul) begin
         m_ff   <= 48'(a_ff.mant) * 48'(b_ff.mant);
         sh_ff  <= a_ff.ex + b_ff.ex + 10'sd24;
         neg_ff <= a_ff.neg ^ b_ff.neg;
         if (a_ff.nan || b_ff.nan) begin
            kind_ff <= K_ZERO;
         end else if (a_ff.inf || b_ff.inf) begin
            if ((!a_ff.inf && a_ff.mant == 24'd0) || (!b_ff.inf && b_ff.mant == 24'd0)) begin
               kind_ff <= K_ZERO;
            end else begin
               kind_ff <= K_SAT;
            end
         end else begin
            kind_ff <= K_NORM;
         end
      end
      if (cmd.sat) begin
         q_ff <= q_in;
      end
      if (cmd.x1) begin
         prod_ff <= 63'(t_val) * 63'(LOG2E_Q30);
      end
      if (cmd.x2) begin
         base_ff <= tab_base;
         dp_ff   <= 42'(tab_diff) * 42'(u_val[20:0]);
         n_ff    <= u_val[28:24];
         zero_ff <= u_val[32:24] >= 9'd25;
      end
      if (cmd.x3) begin
         exp_ff <= exp_in;
      end
      if (cmd.div_start) begin
         r_ff   <= {8'd0, exp_ff};
         quo_ff <= 25'd0;
      end else if (cmd.div_step) begin
         r_ff   <= {div_rem[31:0], 1'b0};
         quo_ff <= {quo_ff[23:0], div_ge};
      end
      if (cmd.enc) begin
         out_ff <= encode_val(quo_ff, value_format);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= NEG_MOST;
         sum_ff <= 32'd0;
         cnt_ff <= 5'd0;
      end else begin
         if (cmd.clr_row) begin
            max_ff <= NEG_MOST;
            sum_ff <= 32'd0;
         end else begin
            if (cmd.store && ($signed(q_ff) > $signed(max_ff))) begin
               max_ff <= q_ff;
            end
            if (cmd.acc) begin
               sum_ff <= sum_ff + {7'd0, exp_ff};
            end
         end
         if (cmd.div_start) begin
            cnt_ff <= 5'd24;
         end else if (cmd.div_step && cnt_ff != 5'd0) begin
            cnt_ff <= cnt_ff - 5'd1;
         end
      end
   end

   assign status.div_last = (cnt_ff == 5'd0);
   assign probability     = out_ff;

endmodule
`default_nettype wire

// ===== hdl/rse_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rse_ctrl
// Sequencer for loading, the sum pass and the normalization pass of a row.
// ----------------------------------------------------------------------------
module rse_ctrl #(
   parameter int ROW_MAX = rse_pkg::ROW_MAX_DEF,
   parameter int ADDR_W  = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [rse_pkg::ROW_LEN_W-1:0]  row_length,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic                                rsp_tlast,
   output rse_pkg::cmd_type                    cmd,
   output logic [ADDR_W-1:0]                   addr,
   input  wire rse_pkg::status_type            status
);
   import rse_pkg::*;

   localparam int CW = $clog2(ROW_MAX + 1);

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_MUL   = 12'b0000_0000_0010,
      ST_SAT   = 12'b0000_0000_0100,
      ST_STORE = 12'b0000_0000_1000,
      ST_READ  = 12'b0000_0001_0000,
      ST_EXP1  = 12'b0000_0010_0000,
      ST_EXP2  = 12'b0000_0100_0000,
      ST_EXP3  = 12'b0000_1000_0000,
      ST_NEXT  = 12'b0001_0000_0000,
      ST_DIV   = 12'b0010_0000_0000,
      ST_ENC   = 12'b0100_0000_0000,
      ST_SEND  = 12'b1000_0000_0000
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] load_ff, load_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] rowcnt_ff, rowcnt_in;
   logic          norm_ff, norm_in;
   logic [CW-1:0] len;
   logic [CW-1:0] load_next;
   logic [CW-1:0] idx_next;

   always_comb begin
      if (row_length == '0) begin
         len = CW'(1);
      end else if ({25'd0, row_length} > ROW_MAX) begin
         len = CW'(ROW_MAX);
      end else begin
         len = CW'(row_length);
      end
   end

   assign load_next = load_ff + CW'(1);
   assign idx_next  = idx_ff + CW'(1);

   always_comb begin
      state_in  = state_ff;
      load_in   = load_ff;
      idx_in    = idx_ff;
      rowcnt_in = rowcnt_ff;
      norm_in   = norm_ff;
      cmd       = '0;
      addr      = idx_ff[ADDR_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            cmd.sat  = 1'b1;
            state_in = ST_STORE;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            addr      = load_ff[ADDR_W-1:0];
            load_in   = load_next;
            if (load_next >= len) begin
               rowcnt_in = load_next;
               idx_in    = '0;
               norm_in   = 1'b0;
               state_in  = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_EXP1;
         end
         ST_EXP1: begin
            cmd.x1   = 1'b1;
            state_in = ST_EXP2;
         end
         ST_EXP2: begin
            cmd.x2   = 1'b1;
            state_in = ST_EXP3;
         end
         ST_EXP3: begin
            cmd.x3   = 1'b1;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            if (norm_ff) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.acc  = 1'b1;
               state_in = ST_READ;
               if (idx_next == rowcnt_ff) begin
                  idx_in  = '0;
                  norm_in = 1'b1;
               end else begin
                  idx_in = idx_next;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_ENC;
            end
         end
         ST_ENC: begin
            cmd.enc  = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_tready) begin
               if (idx_next == rowcnt_ff) begin
                  cmd.clr_row = 1'b1;
                  load_in     = '0;
                  state_in    = ST_IDLE;
               end else begin
                  idx_in   = idx_next;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         load_ff   <= '0;
         idx_ff    <= '0;
         rowcnt_ff <= '0;
         norm_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         load_ff   <= load_in;
         idx_ff    <= idx_in;
         rowcnt_ff <= rowcnt_in;
         norm_ff   <= norm_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_SEND);
   assign rsp_tlast  = (state_ff == ST_SEND) && (idx_next == rowcnt_ff);

`ifndef SYNTH
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted while a result is pending");

   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      load_ff <= CW'(ROW_MAX))
      else $error("load count beyond row capacity");

   a_read_in_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (idx_ff < rowcnt_ff))
      else $error("read outside the stored row");

   a_row_closed: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (load_ff == '0))
      else $error("row not closed after its final transfer");
`endif

endmodule
`default_nettype wire

// ===== hdl/row_softmax_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// row_softmax_engine
// Numerically stable softmax over rows of f32, bf16 or fp16 elements.
// ----------------------------------------------------------------------------
// Each element transfer passes through decode, multiply, saturate and store
// before the next element is accepted. When the last element of a row is
// stored, a sum pass runs each element through the shared exp unit. After
// that, each result passes through a store read, the exp steps EXP1, EXP2
// and EXP3, a divider load, a 25-step restoring divider, encoding and the
// transfer, which waits until the receiver is ready.
// No input is accepted while a row's results are being produced.
// ----------------------------------------------------------------------------
module row_softmax_engine #(
   parameter int ROW_MAX = rse_pkg::ROW_MAX_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [31:0]                    req_tdata,   // element
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [31:0]                    rsp_tdata,   // probability
   output logic                                rsp_tlast,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [rse_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [31:0]                    csr_data
);
   import rse_pkg::*;

   localparam int ADDR_W = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;

   logic [1:0]           fmt_ff;
   logic [31:0]          scale_ff;
   logic [ROW_LEN_W-1:0] len_ff;
   cmd_type              cmd;
   status_type           status;
   logic [ADDR_W-1:0]    addr;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff   <= FMT_F32;
         scale_ff <= SCALE_RESET;
         len_ff   <= ROW_LEN_W'(ROW_MAX_DEF);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FORMAT: fmt_ff   <= csr_data[1:0];
            CSR_SCALE:  scale_ff <= csr_data;
            CSR_LENGTH: len_ff   <= csr_data[ROW_LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   rse_ctrl #(
      .ROW_MAX(ROW_MAX),
      .ADDR_W (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .row_length(len_ff),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tlast (rsp_tlast),
      .cmd       (cmd),
      .addr      (addr),
      .status    (status)
   );

   rse_datapath #(
      .ROW_MAX(ROW_MAX),
      .ADDR_W (ADDR_W)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .addr        (addr),
      .element     (req_tdata),
      .value_format(fmt_ff),
      .scale       (scale_ff),
      .probability (rsp_tdata),
      .status      (status)
   );

endmodule
`default_nettype wire
